@@ hdl/scfd_pkg.sv @@
// Shared types, constants and the byte-wise CRC-32 function for the SLIP
// frame decoder. No dependencies; the front, queue, back and top level import it.
`default_nettype none

package scfd_pkg;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Hold line of trailer bytes.
    localparam int HOLD_DEPTH = 4;
    localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);
    localparam logic [HOLD_CNT_W-1:0] HOLD_FULL = HOLD_CNT_W'(HOLD_DEPTH);

    // Command queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        MODE_HUNT  = 3'b001,
        MODE_FRAME = 3'b010,
        MODE_ESC   = 3'b100
    } t_mode;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_ABORT = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // One byte folded into a reflected CRC-32, eight bit steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/scfd_front.sv @@
// Front part: SLIP unescaping state machine that turns raw bytes into
// push, close and abort commands. Depends on scfd_pkg.
`default_nettype none

module scfd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_rx_byte,
    output scfd_pkg::t_cmd     o_cmd,
    output logic               o_cmd_valid
);
    import scfd_pkg::*;

    t_mode r_mode, n_mode;

    always_comb begin
        n_mode      = r_mode;
        o_cmd_valid = 1'b0;
        o_cmd.op    = OP_PUSH;
        o_cmd.data  = i_rx_byte;
        if (i_accept) begin
            case (r_mode)
                MODE_FRAME: begin
                    if (i_rx_byte == SLIP_END) begin
                        o_cmd_valid = 1'b1;
                        o_cmd.op    = OP_CLOSE;
                        n_mode      = MODE_HUNT;
                    end else if (i_rx_byte == SLIP_ESC) begin
                        n_mode = MODE_ESC;
                    end else begin
                        o_cmd_valid = 1'b1;
                    end
                end
                MODE_ESC: begin
                    if (i_rx_byte == SLIP_END) begin
                        // Escape right before END drops the frame silently.
                        o_cmd_valid = 1'b1;
                        o_cmd.op    = OP_ABORT;
                        n_mode      = MODE_HUNT;
                    end else begin
                        n_mode = MODE_FRAME;
                        if (i_rx_byte == SLIP_ESC_END) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.data  = SLIP_END;
                        end else if (i_rx_byte == SLIP_ESC_ESC) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.data  = SLIP_ESC;
                        end
                    end
                end
                default: begin
                    // Frame state is already clear whenever we hunt.
                    n_mode = (i_rx_byte == SLIP_END) ? MODE_FRAME : MODE_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HUNT;
        end else begin
            r_mode <= n_mode;
        end
    end

endmodule

`default_nettype wire

@@ hdl/scfd_queue.sv @@
// Short command queue in flip-flops between the front and the back.
// Depends on scfd_pkg.
`default_nettype none

module scfd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire scfd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output scfd_pkg::t_cmd     o_head,
    output scfd_pkg::t_qstat   o_stat
);
    import scfd_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hdl/scfd_back.sv @@
// Back part: trailer hold line, running CRC-32 and the output register.
// Executes queued commands. Depends on scfd_pkg.
`default_nettype none

module scfd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire scfd_pkg::t_cmd   i_head,
    input  wire scfd_pkg::t_qstat i_qstat,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_out_kind,
    output logic [7:0]         o_out_byte,
    output logic               o_frame_good
);
    import scfd_pkg::*;

    logic [7:0]            r_hold [HOLD_DEPTH];
    logic [HOLD_CNT_W-1:0] r_cnt;
    logic [31:0]           r_crc;
    logic                  r_out_valid;
    logic                  r_kind, n_kind;
    logic [7:0]            r_byte, n_byte;
    logic                  r_good, n_good;
    logic                  emit;
    logic [31:0]           trailer;

    assign o_pop = !i_qstat.empty && (!r_out_valid || i_ready);
    assign trailer = {r_hold[3], r_hold[2], r_hold[1], r_hold[0]};

    always_comb begin
        emit   = 1'b0;
        n_kind = 1'b0;
        n_byte = r_hold[0];
        n_good = 1'b0;
        case (i_head.op)
            OP_PUSH: begin
                emit = (r_cnt == HOLD_FULL);
            end
            OP_CLOSE: begin
                emit   = (r_cnt != '0);
                n_kind = 1'b1;
                n_byte = 8'd0;
                n_good = (r_cnt == HOLD_FULL) && (trailer == ~r_crc);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_crc       <= CRC_INIT;
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                r_hold[i] <= 8'd0;
            end
        end else begin
            if (o_pop) begin
                r_out_valid <= emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_head.op == OP_PUSH) begin
                    if (r_cnt == HOLD_FULL) begin
                        r_crc <= crc_byte(r_crc, r_hold[0]);
                        for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                            r_hold[i] <= r_hold[i+1];
                        end
                        r_hold[HOLD_DEPTH-1] <= i_head.data;
                    end else begin
                        r_hold[r_cnt[HOLD_CNT_W-2:0]] <= i_head.data;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end else begin
                    r_cnt <= '0;
                    r_crc <= CRC_INIT;
                    for (int i = 0; i < HOLD_DEPTH; i++) begin
                        r_hold[i] <= 8'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_good <= n_good;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_kind   = r_kind;
    assign o_out_byte   = r_byte;
    assign o_frame_good = r_good;

endmodule

`default_nettype wire

@@ hdl/slip_crc_frame_decoder.sv @@
// Top level of the SLIP frame decoder with CRC-32 trailer check.
// Depends on scfd_pkg, scfd_front, scfd_queue and scfd_back.
//
// Usage: the input channel (i_valid, o_ready, i_rx_byte) takes one raw
// serial byte per word. The block hunts for an END byte that opens a frame,
// undoes SLIP escaping, and passes decoded bytes through a four-byte hold
// line. Each byte that leaves the hold line goes out as a payload word
// (o_out_kind 0) and is folded into a reflected CRC-32. At a closing END of
// a non-empty frame a status word (o_out_kind 1) reports in o_frame_good
// whether the frame had at least four bytes and its last four bytes, read
// little-endian, equal the CRC. Payload is streamed, so the receiver drops
// the payload of a frame whose status is bad. An escape right before END
// aborts the frame with no status word.
// An accepted byte's command is queued, then its result word registered.
// The block takes one byte per cycle while o_ready is high; the unescaper,
// the byte-wide CRC update and the output register each handle one word a
// cycle while the receiver is ready. A four-entry command queue separates
// the unescaper from the CRC back end; o_ready drops only when that queue
// is full, which happens when the receiver holds i_ready low long enough.
// A stalled result holds in the output register.
// Reset (i_rst_n low, synchronous) returns to hunting, empties the queue,
// clears the hold line and presets the CRC; no result is valid after it.
`default_nettype none

module slip_crc_frame_decoder (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_out_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_frame_good
);
    import scfd_pkg::*;

    t_cmd   front_cmd;
    logic   front_cmd_valid;
    t_cmd   q_head;
    t_qstat q_stat;
    logic   q_pop;
    logic   in_accept;

    // The front only needs room in the queue to take a byte.
    assign o_ready   = !q_stat.full;
    assign in_accept = i_valid && o_ready;

    scfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_rx_byte   (i_rx_byte),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_cmd_valid)
    );

    scfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_cmd_valid),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // The back pops a command whenever the queue is not empty and its output register is free or
    // being emptied this cycle.
    scfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_qstat      (q_stat),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_frame_good (o_frame_good)
    );

endmodule

`default_nettype wire

@@ hdl/scfd_checker.sv @@
// Port-level checker for the SLIP frame decoder, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module scfd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_out_kind,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_frame_good
);

    // A held result word stays valid.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped while stalled");

    // A held result word keeps its payload.
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out_byte) && $stable(o_out_kind))
        else $error("result word changed while stalled");

    // Status words carry no byte.
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind |-> o_out_byte == 8'd0)
        else $error("status word with nonzero byte");

    // Payload words never claim a good frame.
    a_payload_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_kind |-> !o_frame_good)
        else $error("payload word with frame_good set");

    // Nothing is valid right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind slip_crc_frame_decoder scfd_checker u_scfd_checker (.*);

`default_nettype wire

@@ tb/tb_slip_crc_frame_decoder.sv @@
// Self-checking testbench for slip_crc_frame_decoder: SLIP bytes in, payload and
// frame status words out, checked against a cycle-free model of the decoder.
// Depends on scfd_pkg for the SLIP byte codes, the mode enum and the CRC constants.

module tb_slip_crc_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import scfd_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_WORDS = 1350;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int EXP_DEPTH    = 256;
    localparam int BODY_MAX     = 64;

    // One output word as the decoder presents it.
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       good;
    } dec_word_t;

    // Every input of the block starts at a known value.
    logic       i_clk      = 1'b0;
    logic       rst_n      = 1'b0;
    logic       tx_valid   = 1'b0;
    logic [7:0] tx_byte    = 8'h00;
    logic       sink_ready = 1'b0;

    logic       o_ready;
    logic       o_valid;
    logic       o_out_kind;
    logic [7:0] o_out_byte;
    logic       o_frame_good;

    // When set, neither side inserts gaps or stalls, so that back-to-back
    // traffic at full rate is exercised in between the idle-heavy stretches.
    bit calm = 1'b0;

    int unsigned words_sent  = 0;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    int          stall_left  = 0;

    // Model state: deframer mode, trailer hold line, fill level, running CRC.
    t_mode       dec_mode;
    logic [7:0]  hold_line [4];
    logic [2:0]  hold_fill;
    logic [31:0] frame_crc;

    // Words the decoder owes us, kept in a ring; exp_rd points at the oldest.
    dec_word_t   expected_words [EXP_DEPTH];
    int unsigned exp_wr = 0;
    int unsigned exp_rd = 0;

    slip_crc_frame_decoder uut (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_valid      (tx_valid),
        .o_ready      (o_ready),
        .i_rx_byte    (tx_byte),
        .o_valid      (o_valid),
        .i_ready      (sink_ready),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_frame_good (o_frame_good)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Reflected CRC-32, one data bit at a time: each bit of the byte, LSB
    // first, is XORed into bit 0 before the shift decides on the polynomial.
    function automatic logic [31:0] crc32_fold(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Mostly zero, sometimes a short gap, now and then a long pause; always zero when calm.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Payload content leans toward the SLIP code bytes so that escaping is
    // exercised inside the CRC and the trailer, not just in directed frames.
    function automatic logic [7:0] body_byte();
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: return SLIP_END;
                1: return SLIP_ESC;
                2: return SLIP_ESC_END;
                default: return SLIP_ESC_ESC;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic expect_word(input dec_word_t w);
        expected_words[exp_wr % EXP_DEPTH] = w;
        exp_wr++;
    endtask

    function automatic dec_word_t take_expected();
        dec_word_t w;
        w = expected_words[exp_rd % EXP_DEPTH];
        exp_rd++;
        return w;
    endfunction

    task automatic clear_frame_state();
        for (int i = 0; i < 4; i++) begin
            hold_line[i] = 8'h00;
        end
        hold_fill = 3'd0;
        frame_crc = CRC_INIT;
    endtask

    // A decoded byte enters the hold line. Once four bytes are held, each new
    // one pushes the oldest out as a payload word and into the CRC.
    task automatic hold_decoded(input logic [7:0] b);
        dec_word_t w;
        if (hold_fill == 3'd4) begin
            w.kind = 1'b0;
            w.data = hold_line[0];
            w.good = 1'b0;
            expect_word(w);
            frame_crc = crc32_fold(frame_crc, hold_line[0]);
            hold_line[0] = hold_line[1];
            hold_line[1] = hold_line[2];
            hold_line[2] = hold_line[3];
            hold_line[3] = b;
        end else begin
            hold_line[hold_fill[1:0]] = b;
            hold_fill = hold_fill + 3'd1;
        end
    endtask

    // Advances the model by one accepted serial byte and queues whatever
    // word it produces.
    task automatic decode_rx_byte(input logic [7:0] b);
        dec_word_t   w;
        logic [31:0] trailer;
        case (dec_mode)
            MODE_FRAME: begin
                if (b == SLIP_END) begin
                    // Only a frame that decoded at least one byte reports status.
                    if (hold_fill != 3'd0) begin
                        trailer = {hold_line[3], hold_line[2], hold_line[1], hold_line[0]};
                        w.kind = 1'b1;
                        w.data = 8'h00;
                        w.good = (hold_fill == 3'd4) && (trailer == ~frame_crc);
                        expect_word(w);
                    end
                    clear_frame_state();
                    dec_mode = MODE_HUNT;
                end else if (b == SLIP_ESC) begin
                    dec_mode = MODE_ESC;
                end else begin
                    hold_decoded(b);
                end
            end
            MODE_ESC: begin
                if (b == SLIP_END) begin
                    // Escape right before END: silent abort, back to hunting.
                    clear_frame_state();
                    dec_mode = MODE_HUNT;
                end else begin
                    dec_mode = MODE_FRAME;
                    if (b == SLIP_ESC_END) begin
                        hold_decoded(SLIP_END);
                    end else if (b == SLIP_ESC_ESC) begin
                        hold_decoded(SLIP_ESC);
                    end
                    // Any other byte after an escape is dropped with it.
                end
            end
            default: begin
                if (b == SLIP_END) begin
                    clear_frame_state();
                    dec_mode = MODE_FRAME;
                end else begin
                    dec_mode = MODE_HUNT;
                end
            end
        endcase
    endtask

    // Offers one serial byte, holds it until the decoder takes it, then lets
    // the model see it. Valid stays high across back-to-back bytes.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            tx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tx_valid <= 1'b1;
        tx_byte  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        decode_rx_byte(b);
        words_sent++;
    endtask

    // Builds one frame: body_len random bytes, optionally the little-endian
    // CRC trailer, optionally one flipped bit, then SLIP-encodes it between
    // END bytes. Junk escapes are inserted between symbols when asked, and
    // the frame can be ended by an escape before END to abort it.
    task automatic send_frame(input int body_len, input bit add_crc, input bit corrupt,
                              input bit junk_escapes, input bit abort_end);
        logic [7:0]  body [BODY_MAX];
        int          body_n;
        logic [31:0] crc;
        logic [7:0]  junk;
        int          pos;
        body_n = 0;
        crc = CRC_INIT;
        for (int i = 0; i < body_len; i++) begin
            body[body_n] = body_byte();
            crc = crc32_fold(crc, body[body_n]);
            body_n++;
        end
        if (add_crc) begin
            crc = ~crc;
            for (int i = 0; i < 4; i++) begin
                body[body_n] = crc[8*i +: 8];
                body_n++;
            end
        end
        if (corrupt && body_n > 0) begin
            pos = $urandom_range(0, body_n - 1);
            body[pos][$urandom_range(0, 7)] ^= 1'b1;
        end
        send_byte(SLIP_END);
        for (int i = 0; i < body_n; i++) begin
            if (junk_escapes && $urandom_range(0, 5) == 0) begin
                do begin
                    junk = 8'($urandom_range(0, 255));
                end while (junk == SLIP_END || junk == SLIP_ESC_END || junk == SLIP_ESC_ESC);
                send_byte(SLIP_ESC);
                send_byte(junk);
            end
            if (body[i] == SLIP_END) begin
                send_byte(SLIP_ESC);
                send_byte(SLIP_ESC_END);
            end else if (body[i] == SLIP_ESC) begin
                send_byte(SLIP_ESC);
                send_byte(SLIP_ESC_ESC);
            end else begin
                send_byte(body[i]);
            end
        end
        if (abort_end) begin
            send_byte(SLIP_ESC);
        end
        send_byte(SLIP_END);
    endtask

    // Bytes outside any frame are dropped; END END is an empty frame; a frame
    // whose only content was dropped escapes (unknown escape, ESC ESC) is
    // empty as well. None of this may produce a word.
    task automatic test_noise_and_empty_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SLIP_END);
        send_byte(SLIP_END);
        send_byte(SLIP_END);
        send_byte(SLIP_ESC);
        send_byte(8'h41);
        send_byte(SLIP_ESC);
        send_byte(SLIP_ESC);
        send_byte(SLIP_END);
    endtask

    // Both escape codes decode, giving a three-byte frame: a short frame,
    // so one status word with frame_good low and no payload.
    task automatic test_escapes_short_frame();
        send_byte(SLIP_END);
        send_byte(SLIP_ESC);
        send_byte(SLIP_ESC_END);
        send_byte(SLIP_ESC);
        send_byte(SLIP_ESC_ESC);
        send_byte(8'h7F);
        send_byte(SLIP_END);
    endtask

    // An escape before END aborts silently. The next frame holds just a
    // zero trailer, which is the CRC of no payload, so it reports good.
    task automatic test_abort_then_bare_trailer();
        send_byte(SLIP_END);
        send_byte(8'h11);
        send_byte(SLIP_ESC);
        send_byte(SLIP_END);
        send_byte(SLIP_END);
        repeat (4) send_byte(8'h00);
        send_byte(SLIP_END);
    endtask

    // Mostly well-formed frames with random content; the rest are corrupt,
    // short, aborted, padded with junk escapes, empty, or stray noise.
    task automatic test_random_traffic();
        int unsigned target;
        int          r;
        int          len;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            calm = ($urandom_range(0, 7) == 0);
            r    = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            if (r < 62) begin
                send_frame(len, 1'b1, $urandom_range(0, 4) == 0, 1'b0, 1'b0);
            end else if (r < 72) begin
                send_frame($urandom_range(1, 3), 1'b0, 1'b0, 1'b0, 1'b0);
            end else if (r < 80) begin
                send_frame(len, 1'b1, 1'b0, 1'b1, 1'b0);
            end else if (r < 87) begin
                send_frame($urandom_range(0, 10), 1'b0, 1'b0, 1'b0, 1'b1);
            end else if (r < 94) begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom_range(0, 255)) & 8'hBF);
                end
            end else begin
                send_frame(0, 1'b0, 1'b0, 1'b0, 1'b0);
            end
        end
        calm = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input dec_word_t want, input dec_word_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch (%s) at cycle %0d: expected kind %0d byte %02h good %0d,",
                     what, cycle_count, want.kind, want.data, want.good);
            $display("    got kind %0d byte %02h good %0d", got.kind, got.data, got.good);
        end
    endtask

    // Receiver side: ready stalls of random length, decided at the clock edge.
    always @(posedge i_clk) begin : drive_sink
        if (stall_left > 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            sink_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 30) begin
                stall_left <= pick_gap();
            end
        end
    end

    // Every word taken by the receiver is matched against the oldest
    // expectation. Values read here are the ones held just before the edge.
    always @(posedge i_clk) begin : check_words
        dec_word_t got;
        dec_word_t want;
        if (rst_n && o_valid && sink_ready) begin
            got.kind = o_out_kind;
            got.data = o_out_byte;
            got.good = o_frame_good;
            if (exp_wr == exp_rd) begin
                want = '0;
                report_mismatch("unexpected word", want, got);
            end else begin
                want = take_expected();
                if (got.kind !== want.kind || got.data !== want.data
                        || got.good !== want.good) begin
                    report_mismatch("wrong field", want, got);
                end
            end
        end
    end

    // Hard stop in case the decoder hangs or never delivers an owed word.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        dec_mode = MODE_HUNT;
        clear_frame_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;

        test_noise_and_empty_frames();
        test_escapes_short_frame();
        test_abort_then_bare_trailer();
        test_random_traffic();

        tx_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        // Give a stray extra word a chance to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ slip_crc_frame_decoder.f @@
hdl/scfd_pkg.sv
hdl/scfd_front.sv
hdl/scfd_queue.sv
hdl/scfd_back.sv
hdl/slip_crc_frame_decoder.sv
hdl/scfd_checker.sv
tb/tb_slip_crc_frame_decoder.sv
